// ----- rtl/esw_pkg.sv -----
// Shared types and constants for the encoder speed window average block.
`default_nettype none

package esw_pkg;

  // Field and datapath widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ACC_W     = 38;
  localparam int unsigned STEP_W    = $clog2(ACC_W + 1);
  localparam int unsigned RATE60_W  = 22;

  // Scaling and reset values
  localparam int unsigned        RPM_SECONDS          = 60;
  localparam int unsigned        DEFAULT_WINDOW_DEPTH = 8;
  localparam logic [DATA_W-1:0]  CPR_RESET            = 16'd4;
  localparam logic [DATA_W-1:0]  RATE_RESET           = 16'd200;
  localparam logic [DATA_W-1:0]  SDIV_RESET           = 16'd0;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WRAP  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_REV = 2'd0,
    CFG_SAMPLE_RATE    = 2'd1,
    CFG_SAMPLE_DIV     = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TURNS,
    ST_DELTA,
    ST_AVG,
    ST_RPM_MUL,
    ST_RPM_DIV,
    ST_OUT
  } state_e;

  // Shared unit operations
  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [ACC_W-1:0]  operand;  // multiplicand, or left-aligned dividend
    logic [DATA_W-1:0] factor;   // multiplier, or divisor
    logic [STEP_W-1:0] steps;
  } alu_req_t;

  // Status and results of the shared unit
  typedef struct packed {
    logic             busy;
    logic [ACC_W-1:0] product;
    logic [ACC_W-1:0] quotient;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/esw_alu.sv -----
// Shared shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none

module esw_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire esw_pkg::alu_req_t req_i,
  output esw_pkg::alu_rsp_t      rsp_o
);
  import esw_pkg::*;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  opr_q, opr_d;
  logic [DATA_W-1:0] fac_q, fac_d;
  logic [STEP_W-1:0] step_q, step_d;
  alu_op_e           op_q, op_d;

  logic [DATA_W:0]   rem_sh;
  logic [ACC_W-1:0]  add_a, add_b, add_sum;
  logic              add_sub;

  // Select adder operands: accumulate for multiply, trial subtract for divide
  always_comb begin
    rem_sh  = {acc_q[DATA_W-1:0], opr_q[ACC_W-1]};
    add_a   = acc_q;
    add_b   = fac_q[0] ? opr_q : '0;
    add_sub = 1'b0;
    unique case (op_q)
      ALU_MUL: begin
        add_a   = acc_q;
        add_b   = fac_q[0] ? opr_q : '0;
        add_sub = 1'b0;
      end
      ALU_DIV: begin
        add_a   = ACC_W'(rem_sh);
        add_b   = ACC_W'(fac_q);
        add_sub = 1'b1;
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);
  end

  // Load a new operation or advance one step
  always_comb begin
    acc_d  = acc_q;
    opr_d  = opr_q;
    fac_d  = fac_q;
    step_d = step_q;
    op_d   = op_q;
    if (req_i.start) begin
      acc_d  = '0;
      opr_d  = req_i.operand;
      fac_d  = req_i.factor;
      step_d = req_i.steps;
      op_d   = req_i.op;
    end else if (step_q != '0) begin
      step_d = step_q - STEP_W'(1);
      unique case (op_q)
        ALU_MUL: begin
          acc_d = add_sum;
          opr_d = {opr_q[ACC_W-2:0], 1'b0};
          fac_d = {1'b0, fac_q[DATA_W-1:1]};
        end
        ALU_DIV: begin
          acc_d = add_sum[ACC_W-1] ? ACC_W'(rem_sh) : add_sum;
          opr_d = {opr_q[ACC_W-2:0], ~add_sum[ACC_W-1]};
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      op_q   <= ALU_MUL;
    end else begin
      step_q <= step_d;
      op_q   <= op_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opr_q <= opr_d;
    fac_q <= fac_d;
  end

  assign rsp_o.busy     = (step_q != '0);
  assign rsp_o.product  = acc_q;
  assign rsp_o.quotient = opr_q;

endmodule

`default_nettype wire

// ----- rtl/esw_window.sv -----
// Ring store of sample deltas with per-entry valid bits and a running sum.
`default_nettype none

module esw_window #(
  parameter int unsigned WINDOW_DEPTH = esw_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   clear_i,
  input  wire logic                                   rd_en_i,
  input  wire logic                                   wr_en_i,
  input  wire logic signed [esw_pkg::DATA_W-1:0]      wr_data_i,
  output logic signed [esw_pkg::DATA_W+$clog2(WINDOW_DEPTH)-1:0] sum_o
);
  import esw_pkg::*;

  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SUM_W = DATA_W + $clog2(WINDOW_DEPTH);

  logic signed [DATA_W-1:0] mem_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]  valid_q;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic signed [DATA_W-1:0] rd_data_q;
  logic                     rd_valid_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [DATA_W-1:0] old_entry;

  // An entry never written since reset or clear reads as zero
  assign old_entry = rd_valid_q ? rd_data_q : '0;

  // Advance index and running sum on a write; a clear zeroes the sum
  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    if (clear_i) begin
      sum_d = '0;
    end else if (wr_en_i) begin
      sum_d = sum_q - SUM_W'(old_entry) + SUM_W'(wr_data_i);
      idx_d = (idx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx_q + IDX_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      idx_q      <= '0;
      sum_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[idx_q];
      end
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[idx_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[idx_q];
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- rtl/encoder_speed_window_average.sv -----
// Top level: encoder speed measurement with windowed RPM, sequencer and registers.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in       | in_valid_i / in_ready_o   | kind_i, counter_value_i, count_down_i
//  out      | out_valid_o / out_ready_i | delta_counts_o, speed_rpm_o
//  cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Wrap, clear, ignored and non-sampling tick requests are taken without leaving the idle state.
// A sampling tick holds in_ready_o low until its result is loaded into the output register;
// the shared bit-serial multiply/divide unit runs three operations for it: wraps times
// counts (16 steps), average times rate (16 steps) and the 38-bit quotient by counts
// per revolution (38 steps).
// The window average is a combinational constant reciprocal multiply.
// A result still waiting in the output register holds the sequencer in its last state.
// Reset clears all control state and the window valid bits; no clearing pass.
`default_nettype none

module encoder_speed_window_average #(
  parameter int unsigned WINDOW_DEPTH = esw_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [esw_pkg::KIND_W-1:0]         kind_i,
  input  wire logic [esw_pkg::DATA_W-1:0]         counter_value_i,
  input  wire logic                               count_down_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [esw_pkg::DATA_W-1:0]       delta_counts_o,
  output logic signed [esw_pkg::DATA_W-1:0]       speed_rpm_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [esw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [esw_pkg::DATA_W-1:0]         cfg_data_i
);
  import esw_pkg::*;

  localparam int unsigned SUM_W     = DATA_W + $clog2(WINDOW_DEPTH);
  // Reciprocal of the depth, exact for every window sum magnitude
  localparam int unsigned AVG_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned RECIP_W   = SUM_W + 2;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << AVG_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(RECIP_FULL);

  state_e state_q, state_d;

  logic [DATA_W-1:0] cpr_q, rate_q, sdiv_q;
  logic [DATA_W-1:0] wrap_q, prev_q, tick_q, cnt_val_q;
  logic              first_q, down_q, neg_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] delta_q, out_delta_q, out_rpm_q;

  logic              in_fire, is_sample, out_load, win_rd, win_wr, win_clear;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic signed [SUM_W-1:0] win_sum;
  logic [SUM_W-1:0]  abs_sum;
  logic [PROD_W-1:0] avg_prod;
  logic [DATA_W-1:0] turns, diff, delta_calc, quot16, rpm_calc, cpr_div, avg16;
  logic [RATE60_W-1:0] rate60;

  assign in_fire   = in_valid_i && in_ready_o;
  assign is_sample = (kind_i == KIND_TICK) && (tick_q == '0);
  assign win_clear = in_fire && (kind_i == KIND_CLEAR);

  // Delta arithmetic
  assign turns      = alu_rsp.product[DATA_W-1:0];
  assign diff       = cnt_val_q - prev_q;
  assign delta_calc = first_q ? '0 : (down_q ? turns - diff : diff + turns);

  // Scaling operands
  assign abs_sum  = win_sum[SUM_W-1] ? SUM_W'(-win_sum) : SUM_W'(win_sum);
  assign avg_prod = PROD_W'(abs_sum) * PROD_W'(AVG_RECIP);
  assign avg16    = avg_prod[AVG_SHIFT +: DATA_W];
  assign rate60   = RATE60_W'(rate_q) * RATE60_W'(RPM_SECONDS);
  assign cpr_div  = (cpr_q == '0) ? DATA_W'(1) : cpr_q;
  assign quot16   = alu_rsp.quotient[DATA_W-1:0];
  assign rpm_calc = neg_q ? DATA_W'(-quot16) : quot16;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_fire && is_sample) state_d = ST_TURNS;
      ST_TURNS:   if (!alu_rsp.busy) state_d = ST_DELTA;
      ST_DELTA:   state_d = ST_AVG;
      ST_AVG:     state_d = ST_RPM_MUL;
      ST_RPM_MUL: if (!alu_rsp.busy) state_d = ST_RPM_DIV;
      ST_RPM_DIV: if (!alu_rsp.busy) state_d = ST_OUT;
      ST_OUT:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o      = 1'b0;
    win_rd          = 1'b0;
    win_wr          = 1'b0;
    out_load        = 1'b0;
    alu_req.start   = 1'b0;
    alu_req.op      = ALU_MUL;
    alu_req.operand = '0;
    alu_req.factor  = '0;
    alu_req.steps   = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire && is_sample) begin
          win_rd          = 1'b1;
          alu_req.start   = 1'b1;
          alu_req.op      = ALU_MUL;
          alu_req.operand = ACC_W'(cpr_q);
          alu_req.factor  = wrap_q;
          alu_req.steps   = STEP_W'(DATA_W);
        end
      end
      ST_DELTA: begin
        win_wr = 1'b1;
      end
      ST_AVG: begin
        alu_req.start   = 1'b1;
        alu_req.op      = ALU_MUL;
        alu_req.operand = ACC_W'(rate60);
        alu_req.factor  = avg16;
        alu_req.steps   = STEP_W'(DATA_W);
      end
      ST_RPM_MUL: begin
        if (!alu_rsp.busy) begin
          alu_req.start   = 1'b1;
          alu_req.op      = ALU_DIV;
          alu_req.operand = alu_rsp.product;
          alu_req.factor  = cpr_div;
          alu_req.steps   = STEP_W'(ACC_W);
        end
      end
      ST_OUT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Control and measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpr_q       <= CPR_RESET;
      rate_q      <= RATE_RESET;
      sdiv_q      <= SDIV_RESET;
      wrap_q      <= '0;
      prev_q      <= '0;
      first_q     <= 1'b1;
      tick_q      <= SDIV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_COUNTS_PER_REV: cpr_q  <= cfg_data_i;
          CFG_SAMPLE_RATE:    rate_q <= cfg_data_i;
          CFG_SAMPLE_DIV:     sdiv_q <= cfg_data_i;
          default:            ;
        endcase
      end

      // Decode the accepted request
      if (in_fire) begin
        unique case (kind_i)
          KIND_WRAP: begin
            if (wrap_q != '1) wrap_q <= wrap_q + DATA_W'(1);
          end
          KIND_TICK: begin
            tick_q <= (tick_q != '0) ? tick_q - DATA_W'(1) : sdiv_q;
          end
          KIND_CLEAR: begin
            first_q <= 1'b1;
          end
          default: ;
        endcase
      end

      // Close the sample period
      if (state_q == ST_DELTA) begin
        first_q <= 1'b0;
        wrap_q  <= '0;
        prev_q  <= cnt_val_q;
      end

      // Hold the result until taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && is_sample) begin
      cnt_val_q <= counter_value_i;
      down_q    <= count_down_i;
    end
    if (state_q == ST_DELTA) begin
      delta_q <= delta_calc;
    end
    if (state_q == ST_AVG) begin
      neg_q <= win_sum[SUM_W-1];
    end
    if (out_load) begin
      out_delta_q <= delta_q;
      out_rpm_q   <= rpm_calc;
    end
  end

  esw_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  esw_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (win_clear),
    .rd_en_i   (win_rd),
    .wr_en_i   (win_wr),
    .wr_data_i (delta_calc),
    .sum_o     (win_sum)
  );

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign delta_counts_o = out_delta_q;
  assign speed_rpm_o    = out_rpm_q;

endmodule

`default_nettype wire
